[rtl/hrva_pkg.sv]
// Package for the heart-rate window average block.
// Holds payload structs, the sample entry type, op codes and FSM states.
// No dependencies.
package hrva_pkg;

  // Field widths fixed by the payload
  localparam int unsigned RateW = 8;
  localparam int unsigned VarW  = 16;
  localparam int unsigned IrW   = 18;

  // Default ring depth
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [0:0] {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [RateW-1:0] beats_per_minute;
    logic [VarW-1:0]  beat_variability;
    logic             contact;
    logic [IrW-1:0]   infrared_level;
  } in_t;

  typedef struct packed {
    logic [RateW-1:0] mean_rate;
    logic [VarW-1:0]  mean_variability;
    logic             newest_contact;
    logic [IrW-1:0]   newest_infrared;
  } out_t;

  // One stored ring entry
  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [VarW-1:0]  variability;
    logic             contact;
    logic [IrW-1:0]   infrared;
  } sample_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NEWEST,
    S_LATCH,
    S_DIV_RATE,
    S_START_VAR,
    S_DIV_VAR,
    S_DONE
  } state_e;

endpackage

[rtl/heart_rate_valid_window_average_core.sv]
// Heart-rate window average: sample ring in one synchronous memory.
// Push: writes the ring, no result. Query: the scan reads one entry a cycle through the
// memory read port, then one shared divider runs twice, for the rate and variability means.
// An empty ring skips the scan and the divider and answers with zero means and newest fields.
// One item at a time; the next is taken only once the FSM is back in idle.
// Reset clears pointer, fill count, FSM and output valid; ring contents stay unknown.
module heart_rate_valid_window_average_core #(
  parameter int unsigned DEPTH = hrva_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hrva_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hrva_pkg::out_t out_data_o
);

  localparam int unsigned PtrW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned RateSumW = hrva_pkg::RateW + CntW;
  localparam int unsigned VarSumW  = hrva_pkg::VarW + CntW;

  hrva_pkg::state_e state_q, state_d;

  logic [PtrW-1:0]           wp_q, wp_d;
  logic [CntW-1:0]           fill_q, fill_d;
  logic [CntW-1:0]           idx_q, idx_d;
  logic                      acc_en_q, acc_en_d;
  logic                      clear_acc;
  logic [RateSumW-1:0]       sum_rate_q;
  logic [VarSumW-1:0]        sum_var_q;
  logic [CntW-1:0]           valid_q;
  logic                      new_contact_q, new_contact_d;
  logic [hrva_pkg::IrW-1:0]  new_ir_q, new_ir_d;
  logic [hrva_pkg::RateW-1:0] mean_rate_q, mean_rate_d;
  logic [hrva_pkg::VarW-1:0] mean_var_q, mean_var_d;
  logic                      out_valid_q, out_valid_d;
  hrva_pkg::out_t            out_data_q, out_data_d;

  logic                      in_fire;
  logic                      mem_we, mem_re;
  logic [PtrW-1:0]           mem_raddr, newest_addr;
  hrva_pkg::sample_t         mem_wdata, mem_rdata;

  logic                      div_start, div_done;
  logic [VarSumW-1:0]        div_num, div_quo;

  assign in_ready_o = (state_q == hrva_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign mem_wdata.rate        = in_data_i.beats_per_minute;
  assign mem_wdata.variability = in_data_i.beat_variability;
  assign mem_wdata.contact     = in_data_i.contact;
  assign mem_wdata.infrared    = in_data_i.infrared_level;

  assign newest_addr = (wp_q == '0) ? PtrW'(DEPTH - 1) : wp_q - PtrW'(1);

  hrva_ring_mem #(
    .Depth (DEPTH),
    .AddrW (PtrW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Share one divider between the two means
  assign div_num = (state_q == hrva_pkg::S_START_VAR) ? sum_var_q
                                                      : VarSumW'(sum_rate_q);

  hrva_div #(
    .NumW (VarSumW),
    .DenW (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (valid_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state and control
  always_comb begin
    state_d       = state_q;
    wp_d          = wp_q;
    fill_d        = fill_q;
    idx_d         = idx_q;
    acc_en_d      = 1'b0;
    clear_acc     = 1'b0;
    new_contact_d = new_contact_q;
    new_ir_d      = new_ir_q;
    mean_rate_d   = mean_rate_q;
    mean_var_d    = mean_var_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = idx_q[PtrW-1:0];
    div_start     = 1'b0;

    // Drop output valid once the transfer completes
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      hrva_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == hrva_pkg::OP_PUSH) begin
            mem_we = 1'b1;
            wp_d   = (wp_q == PtrW'(DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
            if (fill_q != CntW'(DEPTH)) begin
              fill_d = fill_q + CntW'(1);
            end
          end else begin
            clear_acc     = 1'b1;
            idx_d         = '0;
            new_contact_d = 1'b0;
            new_ir_d      = '0;
            mean_rate_d   = '0;
            mean_var_d    = '0;
            state_d       = (fill_q == '0) ? hrva_pkg::S_DONE : hrva_pkg::S_SCAN;
          end
        end
      end
      hrva_pkg::S_SCAN: begin
        // Read filled entries in order
        mem_re   = 1'b1;
        acc_en_d = 1'b1;
        if (idx_q == fill_q - CntW'(1)) begin
          state_d = hrva_pkg::S_NEWEST;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      hrva_pkg::S_NEWEST: begin
        mem_re    = 1'b1;
        mem_raddr = newest_addr;
        state_d   = hrva_pkg::S_LATCH;
      end
      hrva_pkg::S_LATCH: begin
        new_contact_d = mem_rdata.contact;
        new_ir_d      = mem_rdata.infrared;
        if (valid_q != '0) begin
          div_start = 1'b1;
          state_d   = hrva_pkg::S_DIV_RATE;
        end else begin
          state_d = hrva_pkg::S_DONE;
        end
      end
      hrva_pkg::S_DIV_RATE: begin
        if (div_done) begin
          mean_rate_d = div_quo[hrva_pkg::RateW-1:0];
          state_d     = hrva_pkg::S_START_VAR;
        end
      end
      hrva_pkg::S_START_VAR: begin
        div_start = 1'b1;
        state_d   = hrva_pkg::S_DIV_VAR;
      end
      hrva_pkg::S_DIV_VAR: begin
        if (div_done) begin
          mean_var_d = div_quo[hrva_pkg::VarW-1:0];
          state_d    = hrva_pkg::S_DONE;
        end
      end
      hrva_pkg::S_DONE: begin
        // Load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                 = 1'b1;
          out_data_d.mean_rate        = mean_rate_q;
          out_data_d.mean_variability = mean_var_q;
          out_data_d.newest_contact   = new_contact_q;
          out_data_d.newest_infrared  = new_ir_q;
          state_d                     = hrva_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hrva_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrva_pkg::S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      acc_en_q    <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      acc_en_q    <= acc_en_d;
      out_valid_q <= out_valid_d;
      if (clear_acc) begin
        valid_q <= '0;
      end else if (acc_en_q && mem_rdata.rate != '0) begin
        valid_q <= valid_q + CntW'(1);
      end
    end
  end

  // Accumulate sums over entries with a nonzero rate
  always_ff @(posedge clk_i) begin
    if (clear_acc) begin
      sum_rate_q <= '0;
      sum_var_q  <= '0;
    end else if (acc_en_q && mem_rdata.rate != '0) begin
      sum_rate_q <= sum_rate_q + RateSumW'(mem_rdata.rate);
      sum_var_q  <= sum_var_q + VarSumW'(mem_rdata.variability);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    new_contact_q <= new_contact_d;
    new_ir_q      <= new_ir_d;
    mean_rate_q   <= mean_rate_d;
    mean_var_q    <= mean_var_d;
    out_data_q    <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("fill count above ring depth");

  a_scan_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hrva_pkg::S_SCAN |-> idx_q < fill_q)
    else $error("scan index beyond filled entries");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == hrva_pkg::S_DONE))
    else $error("result raised outside of the done state");

  a_no_valid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hrva_pkg::S_DONE && valid_q == '0) |->
      (mean_rate_q == '0 && mean_var_q == '0))
    else $error("nonzero mean without valid samples");
`endif

endmodule

[rtl/hrva_ring_mem.sv]
// Sample ring storage: one write port, one read port, registered read data.
// Depends on hrva_pkg for the entry type.
module hrva_ring_mem #(
  parameter int unsigned Depth = hrva_pkg::DefaultDepth,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  hrva_pkg::sample_t    wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output hrva_pkg::sample_t    rdata_o
);

  hrva_pkg::sample_t mem_q [Depth];
  hrva_pkg::sample_t rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, enabled by re_i
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hrva_div.sv]
// Restoring divider, one quotient bit per cycle.
// Standalone; no package dependencies.
module hrva_div #(
  parameter int unsigned NumW = 21,
  parameter int unsigned DenW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_shift;
  logic [DenW+1:0] diff;

  // Trial subtract of the shifted remainder
  assign rem_shift = {rem_q, quo_q[NumW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // Shift in one quotient bit, restore on borrow
      if (diff[DenW+1]) begin
        rem_d = rem_shift[DenW-1:0];
      end else begin
        rem_d = diff[DenW-1:0];
      end
      quo_d = {quo_q[NumW-2:0], ~diff[DenW+1]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[dv/heart_rate_valid_window_average_core_test.sv]
// Testbench for heart_rate_valid_window_average_core: a directed table, then random pushes and
// queries checked against a behavioral window-average predictor, with random stalls.
// Depends on hrva_pkg and the core RTL only.
module heart_rate_valid_window_average_core_test;
  import hrva_pkg::*;

  localparam int unsigned Depth       = DefaultDepth;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned CalmItems   = 60;
  localparam int unsigned SegmentLen  = 24;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 150;
  localparam int unsigned StallLimit  = 3000;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } vector_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Predictor copy of the sample window
  sample_t     model_ring [Depth];
  int unsigned model_wr_ptr = 0;
  int unsigned model_fill   = 0;

  out_t        pending_avgs [$];
  vector_t     directed [$];
  int unsigned err_count    = 0;
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  bit          calm         = 1'b0;

  heart_rate_valid_window_average_core #(.DEPTH(Depth)) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  // Apply one item to the window; a query yields the averages over nonzero-rate entries
  function automatic void predict_window_avg(input in_t item, output bit answers,
                                             output out_t avg);
    int unsigned rate_sum;
    int unsigned var_sum;
    int unsigned valid_cnt;
    int unsigned quot;
    sample_t     newest;
    avg     = '0;
    answers = 1'b0;
    if (item.operation == OP_PUSH) begin
      model_ring[model_wr_ptr] = '{rate: item.beats_per_minute,
                                   variability: item.beat_variability,
                                   contact: item.contact,
                                   infrared: item.infrared_level};
      model_wr_ptr = (model_wr_ptr + 1) % Depth;
      if (model_fill < Depth) model_fill++;
      return;
    end
    answers = 1'b1;
    if (model_fill == 0) return;
    rate_sum  = 0;
    var_sum   = 0;
    valid_cnt = 0;
    for (int unsigned i = 0; i < model_fill; i++) begin
      if (model_ring[i].rate != '0) begin
        rate_sum += model_ring[i].rate;
        var_sum  += model_ring[i].variability;
        valid_cnt++;
      end
    end
    if (valid_cnt != 0) begin
      quot                 = rate_sum / valid_cnt;
      avg.mean_rate        = quot[RateW-1:0];
      quot                 = var_sum / valid_cnt;
      avg.mean_variability = quot[VarW-1:0];
    end
    newest              = model_ring[(model_wr_ptr + Depth - 1) % Depth];
    avg.newest_contact  = newest.contact;
    avg.newest_infrared = newest.infrared;
  endfunction

  function automatic void check_avg(input out_t want, input out_t got);
    if (got.mean_rate !== want.mean_rate) begin
      $error("mean_rate: expected %0d, actual %0d", want.mean_rate, got.mean_rate);
      err_count++;
    end
    if (got.mean_variability !== want.mean_variability) begin
      $error("mean_variability: expected %0d, actual %0d",
             want.mean_variability, got.mean_variability);
      err_count++;
    end
    if (got.newest_contact !== want.newest_contact) begin
      $error("newest_contact: expected %0d, actual %0d", want.newest_contact, got.newest_contact);
      err_count++;
    end
    if (got.newest_infrared !== want.newest_infrared) begin
      $error("newest_infrared: expected %0d, actual %0d",
             want.newest_infrared, got.newest_infrared);
      err_count++;
    end
  endfunction

  function automatic vector_t row(input op_e op, input logic [RateW-1:0] bpm,
                                  input logic [VarW-1:0] hrv, input logic ct,
                                  input logic [IrW-1:0] ir, input bit fixed, input out_t want);
    vector_t v;
    v.item  = '{operation: op, beats_per_minute: bpm, beat_variability: hrv,
                contact: ct, infrared_level: ir};
    v.fixed = fixed;
    v.want  = want;
    return v;
  endfunction

  // Random sample; mode 2 forces invalid rates, mode 3 picks field extremes
  function automatic in_t random_item(input int unsigned mode);
    in_t item;
    item.operation        = ($urandom_range(0, 9) < 6) ? OP_PUSH : OP_QUERY;
    item.beats_per_minute = ($urandom_range(0, 3) == 0) ? '0 : RateW'($urandom_range(0, 255));
    item.beat_variability = VarW'($urandom_range(0, 65535));
    item.contact          = 1'($urandom_range(0, 1));
    item.infrared_level   = IrW'($urandom_range(0, 2**IrW - 1));
    if (mode == 2) item.beats_per_minute = '0;
    if (mode == 3) begin
      item.beats_per_minute = $urandom_range(0, 1) ? '1 : ($urandom_range(0, 1) ? '0 : 8'd1);
      item.beat_variability = $urandom_range(0, 1) ? '1 : '0;
      item.infrared_level   = $urandom_range(0, 1) ? '1 : '0;
    end
    return item;
  endfunction

  // Offer one item, hold it until the transfer, then record what it should produce
  task automatic send_item(input in_t item, input bit fixed, input out_t want);
    bit   answers;
    out_t avg;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_window_avg(item, answers, avg);
    if (answers) pending_avgs.push_back(fixed ? want : avg);
    items_sent++;
  endtask

  // Check each result transfer and track cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_avgs.size() == 0) begin
          $error("result with no pending query: %p", out_data);
          err_count++;
        end else begin
          check_avg(pending_avgs.pop_front(), out_data);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random ready bursts, one long hold-off, steady ready near the end
  initial begin : receiver
    bit held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && items_sent >= HoldAt) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned mode;
    vector_t     v;
    out_t        none;
    none = '0;

    // Empty ring, rate-zero only, single valid entry, ignored query fields
    directed.push_back(row(OP_QUERY, '0, '0, 1'b0, '0, 1'b1, '0));
    directed.push_back(row(OP_PUSH, '0, '1, 1'b1, '1, 1'b0, none));
    directed.push_back(row(OP_QUERY, '0, '0, 1'b0, '0, 1'b1,
                           '{mean_rate: '0, mean_variability: '0,
                             newest_contact: 1'b1, newest_infrared: '1}));
    directed.push_back(row(OP_PUSH, '1, '1, 1'b0, '0, 1'b0, none));
    directed.push_back(row(OP_QUERY, '0, '0, 1'b0, '0, 1'b1,
                           '{mean_rate: '1, mean_variability: '1,
                             newest_contact: 1'b0, newest_infrared: '0}));
    directed.push_back(row(OP_QUERY, '1, '1, 1'b1, '1, 1'b1,
                           '{mean_rate: '1, mean_variability: '1,
                             newest_contact: 1'b0, newest_infrared: '0}));
    // Fill the ring to its full depth
    for (int unsigned i = 2; i < Depth; i++) begin
      directed.push_back(row(OP_PUSH, '1, '1, 1'b1, '1, 1'b0, none));
    end
    directed.push_back(row(OP_QUERY, '0, '0, 1'b0, '0, 1'b1,
                           '{mean_rate: '1, mean_variability: '1,
                             newest_contact: 1'b1, newest_infrared: '1}));
    // Wrap: overwrite the oldest entry
    directed.push_back(row(OP_PUSH, 8'd1, '0, 1'b0, 18'd1, 1'b0, none));
    directed.push_back(row(OP_QUERY, '0, '0, 1'b0, '0, 1'b0, none));
    directed.push_back(row(OP_PUSH, 8'd128, 16'h8000, 1'b1, 18'h20000, 1'b0, none));
    directed.push_back(row(OP_QUERY, '1, '0, 1'b1, '0, 1'b0, none));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      v = directed[i];
      send_item(v.item, v.fixed, v.want);
    end

    // Random part in segments of one flavor each
    mode = 0;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % SegmentLen == 0) mode = $urandom_range(0, 3);
      if (n >= RandomItems - CalmItems) calm = 1'b1;
      send_item(random_item(mode), 1'b0, none);
    end
    in_valid <= 1'b0;

    // Drain, then let the core settle
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
